@@ sv/dmip_pkg.sv @@
// Shared types, constants and the steering factor table builder for the
// dual motor incremental PID controller. No dependencies.
package dmip_pkg;

  // Steering table and loop limits
  localparam int STEER_TABLE_DEPTH = 1024;
  localparam int STEER_IDX_W       = $clog2(STEER_TABLE_DEPTH);
  localparam int DRIVE_LIMIT       = 45000;
  localparam int STEER_DEADBAND    = 10;
  localparam int STEER_MAX         = 1000;

  // Field widths
  localparam int SPEED_W  = 12;
  localparam int GAIN_W   = 16;
  localparam int MEAS_W   = 13;
  localparam int STEER_W  = 11;
  localparam int ELEM_W   = 2;
  localparam int ERR_W    = 14;
  localparam int DRIVE_W  = 17;
  localparam int FACTOR_W = 16;

  // Shared multiplier: 17x17 signed
  localparam int MUL_W  = 17;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = PROD_W + 2;

  // Configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Fixed point constants for the table builder
  localparam longint unsigned Q30_ONE  = 64'd1 << 30;
  localparam longint unsigned TERM_DEN = 64'd1000 * Q30_ONE;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_NORMAL = 8'd0,
    CFG_SPEED_CIRCLE = 8'd1,
    CFG_LEFT_KP      = 8'd2,
    CFG_LEFT_KI      = 8'd3,
    CFG_LEFT_KD      = 8'd4,
    CFG_RIGHT_KP     = 8'd5,
    CFG_RIGHT_KI     = 8'd6,
    CFG_RIGHT_KD     = 8'd7
  } cfg_idx_t;

  // Track element codes
  typedef enum logic [ELEM_W-1:0] {
    ELEM_NORMAL     = 2'd0,
    ELEM_ROUNDABOUT = 2'd1,
    ELEM_UNKNOWN    = 2'd2,
    ELEM_UNDEF      = 2'd3
  } elem_t;

  typedef logic signed [MUL_W-1:0]    mul_op_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic [STEER_IDX_W-1:0]     steer_idx_t;
  typedef logic [FACTOR_W-1:0]        steer_factor_t;
  typedef steer_factor_t              steer_tab_t [STEER_TABLE_DEPTH];

  // Restoring long division, unsigned 64 bit. Elaboration only.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q1.15 factor 1 - 0.396*|tan(a*3.14/5100)|, angle in Q30, Taylor series
  // for sin (to x^9) and cos (to x^10). Elaboration only.
  function automatic steer_factor_t steer_factor(input longint unsigned a);
    longint unsigned x, p2, p3, p4, p5, p6, p7, p8, p9, p10;
    longint unsigned sn, cs, tn, term;
    x    = (a * 64'd314 * Q30_ONE + 64'd255000) / 64'd510000;
    p2   = (x * x) >> 30;
    p3   = (p2 * x) >> 30;
    p4   = (p3 * x) >> 30;
    p5   = (p4 * x) >> 30;
    p6   = (p5 * x) >> 30;
    p7   = (p6 * x) >> 30;
    p8   = (p7 * x) >> 30;
    p9   = (p8 * x) >> 30;
    p10  = (p9 * x) >> 30;
    sn   = (x + p5 / 64'd120 + p9 / 64'd362880) - (p3 / 64'd6 + p7 / 64'd5040);
    cs   = (Q30_ONE + p4 / 64'd24 + p8 / 64'd40320)
         - (p2 / 64'd2 + p6 / 64'd720 + p10 / 64'd3628800);
    tn   = udiv64(sn << 30, cs);
    term = (tn * 64'd396 * 64'd32768 + 64'd500 * Q30_ONE) / TERM_DEN;
    return FACTOR_W'(64'd32768 - term);
  endfunction

  // Whole table; entries past the steering limit repeat the last angle
  function automatic steer_tab_t build_steer_tab();
    steer_tab_t tab;
    for (int i = 0; i < STEER_TABLE_DEPTH; i++) begin
      tab[i] = steer_factor((i > STEER_MAX) ? 64'(STEER_MAX) : 64'(i));
    end
    return tab;
  endfunction

endpackage

@@ sv/dmip_steer_rom.sv @@
// Steering factor ROM with registered read data.
// Depends on dmip_pkg for the table contents and widths.
module dmip_steer_rom (
  input  logic                    clk,
  input  dmip_pkg::steer_idx_t    addr,
  output dmip_pkg::steer_factor_t rd_data_r
);
  import dmip_pkg::*;

  localparam steer_tab_t STEER_ROM = build_steer_tab();

  // One read per cycle
  always_ff @(posedge clk) begin
    rd_data_r <= STEER_ROM[addr];
  end

endmodule

@@ sv/dmip_mul.sv @@
// Shared 17x17 signed multiplier with a registered product.
// Depends on dmip_pkg for operand and product types.
module dmip_mul (
  input  logic              clk,
  input  dmip_pkg::mul_op_t op_a,
  input  dmip_pkg::mul_op_t op_b,
  output dmip_pkg::prod_t   prod_r
);
  import dmip_pkg::*;

  // operands sign extended to the product width
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

@@ sv/dual_motor_incremental_pid.sv @@
// Dual motor incremental PID with steering differential.
// One item at a time: in_tready is high only in the idle state, so the next item
// is taken only after the previous result is loaded into the output register. The
// six PID products and the steering scale share one 17x17 multiplier, and the factor
// ROM read is registered. A result held by out_tready keeps the sequencer in its output state.
// Reset (rst_n low, synchronous) clears gains, speeds, targets, error history
// and accumulators; the factor table is a ROM and needs no clearing.
module dual_motor_incremental_pid (
  input  logic                           clk,
  input  logic                           rst_n,
  // tdata: left_measured[12:0], right_measured[25:13], steer_offset[36:26],
  //        running[37], track_element[39:38]
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,
  // tdata: left_drive[16:0], right_drive[33:17], beep[34], zero[39:35]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [39:0]                    out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dmip_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dmip_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dmip_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ROM, S_SCALE, S_ERR, S_MAC, S_UPD, S_OUT
  } state_t;

  localparam int MAC_STEPS = 7;   // six products plus one drain step
  localparam int CNT_W     = 3;

  // Config registers
  logic [SPEED_W-1:0] speed_normal_r, speed_circle_r;
  logic [GAIN_W-1:0]  left_kp_r, left_ki_r, left_kd_r;
  logic [GAIN_W-1:0]  right_kp_r, right_ki_r, right_kd_r;

  // Sequencer and datapath registers
  state_t                    state_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [SPEED_W-1:0]        base_r;
  logic                      beep_r;
  logic                      scale_left_r, scale_right_r;
  steer_idx_t                idx_r;
  logic signed [MEAS_W-1:0]  lm_r, rm_r;
  logic signed [ERR_W-1:0]   le_r, re_r;
  logic signed [ERR_W-1:0]   left_e1_r, left_e2_r, right_e1_r, right_e2_r;
  logic signed [DRIVE_W-1:0] left_acc_r, right_acc_r;
  logic signed [SUM_W-1:0]   sum_l_r, sum_r_r;
  logic                      out_valid_r;
  logic [39:0]               out_tdata_r;

  // Input field views
  logic signed [MEAS_W-1:0]  in_lm, in_rm;
  logic signed [STEER_W-1:0] in_steer, steer_sat;
  logic                      in_running;
  elem_t                     in_elem;
  logic [9:0]                steer_abs;
  steer_idx_t                idx_nxt;
  logic [SPEED_W-1:0]        base_nxt;
  logic                      beep_nxt;

  // Shared unit wiring
  steer_factor_t             rom_data;
  mul_op_t                   mul_a, mul_b;
  prod_t                     prod;

  // Error terms
  logic [SPEED_W-1:0]        lt_nxt, rt_nxt;
  logic signed [ERR_W-1:0]   le_nxt, re_nxt;
  logic signed [ERR_W:0]     dp_l, dp_r;
  logic signed [ERR_W+1:0]   dd_l, dd_r;
  logic signed [SUM_W-1:0]   prod_ext;

  // Config write port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_normal_r <= '0;
      speed_circle_r <= '0;
      left_kp_r      <= '0;
      left_ki_r      <= '0;
      left_kd_r      <= '0;
      right_kp_r     <= '0;
      right_ki_r     <= '0;
      right_kd_r     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPEED_NORMAL: speed_normal_r <= cfg_data[SPEED_W-1:0];
        CFG_SPEED_CIRCLE: speed_circle_r <= cfg_data[SPEED_W-1:0];
        CFG_LEFT_KP:      left_kp_r      <= cfg_data;
        CFG_LEFT_KI:      left_ki_r      <= cfg_data;
        CFG_LEFT_KD:      left_kd_r      <= cfg_data;
        CFG_RIGHT_KP:     right_kp_r     <= cfg_data;
        CFG_RIGHT_KI:     right_ki_r     <= cfg_data;
        CFG_RIGHT_KD:     right_kd_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack and condition the input item
  assign in_lm      = in_tdata[12:0];
  assign in_rm      = in_tdata[25:13];
  assign in_steer   = in_tdata[36:26];
  assign in_running = in_tdata[37];
  assign in_elem    = elem_t'(in_tdata[39:38]);

  always_comb begin
    if (int'(in_steer) > STEER_MAX) begin
      steer_sat = STEER_W'(STEER_MAX);
    end else if (int'(in_steer) < -STEER_MAX) begin
      steer_sat = STEER_W'(-STEER_MAX);
    end else begin
      steer_sat = in_steer;
    end
    steer_abs = steer_sat[STEER_W-1] ? 10'(-steer_sat) : 10'(steer_sat);
    if (int'(steer_abs) > STEER_TABLE_DEPTH - 1) begin
      idx_nxt = STEER_IDX_W'(STEER_TABLE_DEPTH - 1);
    end else begin
      idx_nxt = STEER_IDX_W'(steer_abs);
    end
  end

  // Target selection
  always_comb begin
    base_nxt = base_r;
    beep_nxt = 1'b0;
    if (!in_running) begin
      base_nxt = '0;
    end else begin
      case (in_elem)
        ELEM_NORMAL:     base_nxt = speed_normal_r;
        ELEM_ROUNDABOUT: base_nxt = speed_circle_r;
        default:         beep_nxt = 1'b1;
      endcase
    end
  end

  dmip_steer_rom u_rom (
    .clk       (clk),
    .addr      (idx_r),
    .rd_data_r (rom_data)
  );

  // Inner wheel target and errors, product of base*factor is in prod
  always_comb begin
    lt_nxt = base_r;
    rt_nxt = base_r;
    if (scale_left_r) begin
      lt_nxt = prod[SPEED_W+14:15];
    end
    if (scale_right_r) begin
      rt_nxt = prod[SPEED_W+14:15];
    end
    le_nxt = $signed({2'b00, lt_nxt}) - $signed({lm_r[MEAS_W-1], lm_r});
    re_nxt = $signed({2'b00, rt_nxt}) - $signed({rm_r[MEAS_W-1], rm_r});
  end

  // Difference terms
  assign dp_l = {le_r[ERR_W-1], le_r} - {left_e1_r[ERR_W-1], left_e1_r};
  assign dp_r = {re_r[ERR_W-1], re_r} - {right_e1_r[ERR_W-1], right_e1_r};
  assign dd_l = {{2{le_r[ERR_W-1]}}, le_r} - {left_e1_r[ERR_W-1], left_e1_r, 1'b0}
              + {{2{left_e2_r[ERR_W-1]}}, left_e2_r};
  assign dd_r = {{2{re_r[ERR_W-1]}}, re_r} - {right_e1_r[ERR_W-1], right_e1_r, 1'b0}
              + {{2{right_e2_r[ERR_W-1]}}, right_e2_r};

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SCALE) begin
      mul_a = mul_op_t'({5'b0, base_r});
      mul_b = mul_op_t'({1'b0, rom_data});
    end else if (state_r == S_MAC) begin
      case (cnt_r)
        3'd0: begin
          mul_a = {1'b0, left_ki_r};
          mul_b = MUL_W'(le_r);
        end
        3'd1: begin
          mul_a = {1'b0, left_kp_r};
          mul_b = MUL_W'(dp_l);
        end
        3'd2: begin
          mul_a = {1'b0, left_kd_r};
          mul_b = MUL_W'(dd_l);
        end
        3'd3: begin
          mul_a = {1'b0, right_ki_r};
          mul_b = MUL_W'(re_r);
        end
        3'd4: begin
          mul_a = {1'b0, right_kp_r};
          mul_b = MUL_W'(dp_r);
        end
        3'd5: begin
          mul_a = {1'b0, right_kd_r};
          mul_b = MUL_W'(dd_r);
        end
        default: ;
      endcase
    end
  end

  dmip_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  assign prod_ext = SUM_W'(prod);

  // sum/256 toward zero, add to accumulator, clamp
  function automatic logic signed [DRIVE_W-1:0] drive_upd(
    input logic signed [DRIVE_W-1:0] acc,
    input logic signed [SUM_W-1:0]   sum
  );
    logic signed [SUM_W-1:0]   biased;
    logic signed [SUM_W-9:0]   d;
    logic signed [SUM_W-8:0]   n;
    biased = sum + (sum[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
    d      = (SUM_W-8)'(biased >>> 8);
    n      = (SUM_W-7)'(acc) + (SUM_W-7)'(d);
    if (n > DRIVE_LIMIT) begin
      return DRIVE_W'(DRIVE_LIMIT);
    end else if (n < -DRIVE_LIMIT) begin
      return DRIVE_W'(-DRIVE_LIMIT);
    end else begin
      return DRIVE_W'(n);
    end
  endfunction

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      base_r      <= '0;
      left_e1_r   <= '0;
      left_e2_r   <= '0;
      right_e1_r  <= '0;
      right_e2_r  <= '0;
      left_acc_r  <= '0;
      right_acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the output state reloads the register itself
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            lm_r          <= in_lm;
            rm_r          <= in_rm;
            base_r        <= base_nxt;
            beep_r        <= beep_nxt;
            idx_r         <= idx_nxt;
            scale_left_r  <= int'(steer_sat) >= STEER_DEADBAND;
            scale_right_r <= int'(steer_sat) <= -STEER_DEADBAND;
            state_r       <= S_ROM;
          end
        end
        S_ROM: begin
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          state_r <= S_ERR;
        end
        S_ERR: begin
          le_r    <= le_nxt;
          re_r    <= re_nxt;
          sum_l_r <= '0;
          sum_r_r <= '0;
          cnt_r   <= '0;
          state_r <= S_MAC;
        end
        S_MAC: begin
          // product of step cnt-1 arrives now
          if (cnt_r >= 3'd1 && cnt_r <= 3'd3) begin
            sum_l_r <= sum_l_r + prod_ext;
          end else if (cnt_r >= 3'd4) begin
            sum_r_r <= sum_r_r + prod_ext;
          end
          if (cnt_r == CNT_W'(MAC_STEPS - 1)) begin
            state_r <= S_UPD;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_UPD: begin
          left_acc_r  <= drive_upd(left_acc_r, sum_l_r);
          right_acc_r <= drive_upd(right_acc_r, sum_r_r);
          left_e2_r   <= left_e1_r;
          left_e1_r   <= le_r;
          right_e2_r  <= right_e1_r;
          right_e1_r  <= re_r;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_tdata_r <= {5'b0, beep_r, right_acc_r, left_acc_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ verif/dmip_drive_checker.sv @@
`timescale 1ns / 1ps
// Drive checker for dual_motor_incremental_pid: watches the config, tick and drive
// streams, predicts every drive item from its own copy of the controller state
// and compares it field by field. Depends on dmip_pkg only.
module dmip_drive_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [39:0]                     in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [39:0]                     out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [dmip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmip_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              checked,
  output int                              clamped,
  output int                              beeped
);
  import dmip_pkg::*;

  // One drive item as it sits on out_tdata, lowest field last
  typedef struct packed {
    logic [4:0]                pad;
    logic                      beep;
    logic signed [DRIVE_W-1:0] right;
    logic signed [DRIVE_W-1:0] left;
  } drive_t;

  logic [FACTOR_W-1:0] inner_scale [STEER_TABLE_DEPTH];

  logic [SPEED_W-1:0] spd_normal, spd_circle, base_speed;
  logic [GAIN_W-1:0]  l_kp, l_ki, l_kd, r_kp, r_ki, r_kd;
  int                 l_e1, l_e2, r_e1, r_e2;
  longint             l_acc, r_acc;
  drive_t             drive_expect_q [$];

  // Inner wheel scale 1 - 0.396*|tan(a*3.14/5100)| in Q1.15, integer Taylor sums
  initial begin : fill_scale
    longint unsigned one_q30, x, pw, fact, sn, cs, tn, term;
    int              angle;
    one_q30 = 64'd1 << 30;
    for (int i = 0; i < STEER_TABLE_DEPTH; i++) begin
      angle = (i > STEER_MAX) ? STEER_MAX : i;
      x     = (64'(angle) * 64'd314 * one_q30 + 64'd255000) / 64'd510000;
      sn    = x;
      cs    = one_q30;
      pw    = x;
      fact  = 1;
      // odd powers feed sine, even powers cosine; signs alternate by pairs
      for (int k = 2; k <= 10; k++) begin
        pw   = (pw * x) >> 30;
        fact = fact * k;
        if (k % 2 == 0) begin
          if (k % 4 == 0) cs = cs + pw / fact;
          else            cs = cs - pw / fact;
        end else begin
          if (k % 4 == 1) sn = sn + pw / fact;
          else            sn = sn - pw / fact;
        end
      end
      tn   = (sn << 30) / cs;
      term = (tn * 64'd396 * 64'd32768 + 64'd500 * one_q30) / (64'd1000 * one_q30);
      inner_scale[i] = FACTOR_W'(64'd32768 - term);
    end
  end

  // Incremental PID step: exact sum, divide by 256 toward zero, clamp
  function automatic longint pid_update(input longint acc, input int e, input int e1,
                                        input int e2, input logic [GAIN_W-1:0] kp,
                                        input logic [GAIN_W-1:0] ki,
                                        input logic [GAIN_W-1:0] kd);
    longint sum;
    sum = longint'(ki) * e + longint'(kp) * (e - e1) + longint'(kd) * (e - 2 * e1 + e2);
    acc = acc + sum / 256;
    if (acc > DRIVE_LIMIT)       acc = DRIVE_LIMIT;
    else if (acc < -DRIVE_LIMIT) acc = -DRIVE_LIMIT;
    return acc;
  endfunction

  always @(posedge clk) begin : watch
    logic signed [MEAS_W-1:0]  lm, rm;
    logic signed [STEER_W-1:0] steer_raw;
    int                        steer, idx, lt, rt, le, re;
    elem_t                     elem;
    logic                      run, beep;
    drive_t                    want, got;
    if (!rst_n) begin
      spd_normal = '0;
      spd_circle = '0;
      base_speed = '0;
      {l_kp, l_ki, l_kd, r_kp, r_ki, r_kd} = '0;
      {l_e1, l_e2, r_e1, r_e2} = '0;
      l_acc      = 0;
      r_acc      = 0;
      drive_expect_q.delete();
      mismatches = 0;
      checked    = 0;
      clamped    = 0;
      beeped     = 0;
    end else begin
      // drive items against the oldest expectation
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (drive_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: drive item %h with nothing expected", $realtime, out_tdata);
        end else begin
          want = drive_expect_q.pop_front();
          checked++;
          if (got.left !== want.left || got.right !== want.right ||
              got.beep !== want.beep || got.pad !== want.pad) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: drive mismatch, expected L %0d R %0d beep %b pad %h,",
                        " got L %0d R %0d beep %b pad %h"},
                       $realtime, want.left, want.right, want.beep, want.pad,
                       got.left, got.right, got.beep, got.pad);
          end
        end
      end

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPEED_NORMAL: spd_normal = cfg_data[SPEED_W-1:0];
          CFG_SPEED_CIRCLE: spd_circle = cfg_data[SPEED_W-1:0];
          CFG_LEFT_KP:      l_kp = cfg_data;
          CFG_LEFT_KI:      l_ki = cfg_data;
          CFG_LEFT_KD:      l_kd = cfg_data;
          CFG_RIGHT_KP:     r_kp = cfg_data;
          CFG_RIGHT_KI:     r_ki = cfg_data;
          CFG_RIGHT_KD:     r_kd = cfg_data;
          default: ;  // indexes past the last register are dropped
        endcase
      end

      // control tick: target, differential, two PID loops
      if (in_tvalid && in_tready) begin
        lm        = in_tdata[12:0];
        rm        = in_tdata[25:13];
        steer_raw = in_tdata[36:26];
        run       = in_tdata[37];
        elem      = elem_t'(in_tdata[39:38]);
        steer     = steer_raw;
        if (steer > STEER_MAX)  steer = STEER_MAX;
        if (steer < -STEER_MAX) steer = -STEER_MAX;

        beep = 1'b0;
        if (!run) base_speed = '0;
        else begin
          case (elem)
            ELEM_NORMAL:     base_speed = spd_normal;
            ELEM_ROUNDABOUT: base_speed = spd_circle;
            default:         beep = 1'b1;  // unknown element keeps the old target
          endcase
        end

        lt  = base_speed;
        rt  = base_speed;
        idx = (steer < 0) ? -steer : steer;
        if (idx > STEER_TABLE_DEPTH - 1) idx = STEER_TABLE_DEPTH - 1;
        if (steer <= -STEER_DEADBAND)     rt = (rt * inner_scale[idx]) >> 15;
        else if (steer >= STEER_DEADBAND) lt = (lt * inner_scale[idx]) >> 15;

        le    = lt - lm;
        re    = rt - rm;
        l_acc = pid_update(l_acc, le, l_e1, l_e2, l_kp, l_ki, l_kd);
        r_acc = pid_update(r_acc, re, r_e1, r_e2, r_kp, r_ki, r_kd);
        l_e2  = l_e1;
        l_e1  = le;
        r_e2  = r_e1;
        r_e1  = re;

        want.left  = l_acc[DRIVE_W-1:0];
        want.right = r_acc[DRIVE_W-1:0];
        want.beep  = beep;
        want.pad   = '0;
        drive_expect_q.push_back(want);
        if (beep) beeped++;
        if (l_acc == DRIVE_LIMIT || l_acc == -DRIVE_LIMIT ||
            r_acc == DRIVE_LIMIT || r_acc == -DRIVE_LIMIT) clamped++;
      end
    end
    pending = drive_expect_q.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Stimulus and verdict for dual_motor_incremental_pid: directed ticks, then random
// phases under several gain/speed settings and idle patterns. Depends on dmip_pkg,
// the block and dmip_drive_checker.
module tb;
  import dmip_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PHASE_TICKS  = 200;
  localparam int DRAIN_CYCLES = 20;

  // writes to these must leave every register alone
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX    = 8'hFF;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [39:0]           in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [39:0]           out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int mismatches, pending, checked, clamped, beeped;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int nominal       = 0;
  int cycles        = 0;
  int ticks_sent    = 0;
  int settings_run  = 0;

  dual_motor_incremental_pid DUT (.*);
  dmip_drive_checker drive_chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // result side backpressure
  always @(negedge clk) out_tready = ($urandom_range(0, 99) >= sink_idle_pct);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d drive items outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [39:0] pack_tick(input int lm, input int rm, input int steer,
                                            input bit run, input elem_t elem);
    return {elem, run, 11'(steer), 13'(rm), 13'(lm)};
  endfunction

  // wheel speed mostly near the commanded speed, sometimes anywhere
  function automatic int wheel_speed();
    int v;
    if ($urandom_range(0, 9) < 3) return int'($urandom_range(0, 8191)) - 4096;
    v = nominal + int'($urandom_range(0, 600)) - 300;
    return (v > 4095) ? 4095 : v;
  endfunction

  task automatic send_tick(input logic [39:0] d);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = d;
    do @(posedge clk); while (!in_tready);
    ticks_sent++;
  endtask

  // stop sending and wait for every expected drive item
  task automatic hold_off();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic settle();
    hold_off();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_setting(input logic [15:0] sn, input logic [15:0] sc,
                              input logic [15:0] lkp, input logic [15:0] lki,
                              input logic [15:0] lkd, input logic [15:0] rkp,
                              input logic [15:0] rki, input logic [15:0] rkd);
    write_reg(CFG_SPEED_NORMAL, sn);
    write_reg(CFG_SPEED_CIRCLE, sc);
    write_reg(CFG_LEFT_KP, lkp);
    write_reg(CFG_LEFT_KI, lki);
    write_reg(CFG_LEFT_KD, lkd);
    write_reg(CFG_RIGHT_KP, rkp);
    write_reg(CFG_RIGHT_KI, rki);
    write_reg(CFG_RIGHT_KD, rkd);
    nominal = sn[SPEED_W-1:0];
    settings_run++;
  endtask

  // speeds carry random upper bits to exercise the register masking
  task automatic load_random_setting(input int gain_max);
    load_setting(16'($urandom), 16'($urandom),
                 16'($urandom_range(0, gain_max)), 16'($urandom_range(0, gain_max)),
                 16'($urandom_range(0, gain_max)), 16'($urandom_range(0, gain_max)),
                 16'($urandom_range(0, gain_max)), 16'($urandom_range(0, gain_max)));
  endtask

  task automatic random_ticks(input int count);
    int    lm, rm, steer, pick;
    bit    run;
    elem_t elem;
    for (int n = 0; n < count; n++) begin
      run  = ($urandom_range(0, 9) != 0);
      pick = $urandom_range(0, 9);
      elem = (pick < 6) ? ELEM_NORMAL : (pick < 8) ? ELEM_ROUNDABOUT :
             (pick == 8) ? ELEM_UNKNOWN : ELEM_UNDEF;
      pick = $urandom_range(0, 9);
      if (pick == 0)      steer = int'($urandom_range(0, 40)) - 20;      // around deadband
      else if (pick == 1) steer = int'($urandom_range(0, 2047)) - 1024;  // full field
      else                steer = int'($urandom_range(0, 2000)) - 1000;
      lm = wheel_speed();
      rm = wheel_speed();
      if ($urandom_range(0, 49) == 0) hold_off();
      send_tick(pack_tick(lm, rm, steer, run, elem));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: run flag, every element code, deadband edges, steering and speed extremes
    src_idle_pct  = 37;
    sink_idle_pct = 77;
    load_setting(16'd1500, 16'hF384, 16'h0300, 16'h0080, 16'h0040,
                 16'h0280, 16'h0100, 16'h0020);
    send_tick(pack_tick(0, 0, 0, 1'b0, ELEM_NORMAL));
    send_tick(pack_tick(0, 0, 0, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(100, -100, 0, 1'b1, ELEM_ROUNDABOUT));
    send_tick(pack_tick(800, 900, 0, 1'b1, ELEM_UNKNOWN));
    send_tick(pack_tick(850, 880, 0, 1'b1, ELEM_UNDEF));
    send_tick(pack_tick(900, 900, 0, 1'b0, ELEM_UNKNOWN));
    send_tick(pack_tick(1400, 1400, 9, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(1400, 1400, -9, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(1400, 1400, 10, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(1400, 1400, -10, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(1200, 1500, 1000, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(1500, 1200, -1000, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(1200, 1500, 1023, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(1500, 1200, -1024, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(-4096, 4095, 0, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(4095, -4096, 0, 1'b1, ELEM_NORMAL));
    send_tick(pack_tick(600, 900, 500, 1'b1, ELEM_ROUNDABOUT));
    send_tick(pack_tick(900, 600, -500, 1'b1, ELEM_UNKNOWN));
    send_tick(pack_tick(-4096, -4096, 1023, 1'b0, ELEM_UNDEF));
    send_tick(pack_tick(4095, 4095, 0, 1'b1, ELEM_NORMAL));

    // random phases: sender idles less than the receiver first
    random_ticks(PHASE_TICKS);
    settle();
    load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_ticks(PHASE_TICKS);

    // then the receiver idles less; all gains zero, plus writes that must be dropped
    settle();
    src_idle_pct  = 77;
    sink_idle_pct = 37;
    load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000, 16'h0000);
    write_reg(CFG_UNUSED_IDX, 16'h0FFF);
    write_reg(CFG_TOP_IDX, 16'hFFFF);
    random_ticks(PHASE_TICKS);
    settle();
    load_random_setting(2047);
    random_ticks(PHASE_TICKS);

    // no idling on either side
    settle();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_random_setting(2047);
    random_ticks(PHASE_TICKS);
    settle();
    load_random_setting(65535);
    random_ticks(PHASE_TICKS);

    settle();
    $display("Covered %0d control ticks under %0d speed/gain settings with deadband,",
             ticks_sent, settings_run);
    $display("saturated steering and every element code; %0d drive items checked, %0d clamped, %0d beeping.",
             checked, clamped, beeped);
    if (mismatches == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dmip_pkg.sv
sv/dmip_steer_rom.sv
sv/dmip_mul.sv
sv/dual_motor_incremental_pid.sv
verif/dmip_drive_checker.sv
verif/tb.sv
